### hw/rtl/linear_probe_hash_map_top_assert.svh
// Assertion macros shared by the hash map checker.
`ifndef LINEAR_PROBE_HASH_MAP_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_TOP_ASSERT_SVH

// Implication checked at the same clock edge.
`define LPHM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lphm check failed: lbl");

// Implication checked at the next clock edge.
`define LPHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lphm check failed: lbl");

`endif

### hw/rtl/lphm_pkg.sv
// Shared constants, codes and types of the linear probing hash map.
`default_nettype none
package lphm_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int LOAD_LIMIT  = (TABLE_SLOTS * 3) / 4;

  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  localparam int IN_FIELDS_W  = CMD_W + KEY_W + VAL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STAT_W + VAL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNUSED  = 2'd3;

  // Write request from the sequencer to the slot store.
  typedef struct packed {
    logic             mem_we;     // write key and value at addr
    logic             mark_live;  // slot becomes live, tombstone cleared
    logic             mark_tomb;  // slot becomes a tombstone
    logic [IDX_W-1:0] addr;
  } lphm_wr_t;

  // Registered contents of one slot.
  typedef struct packed {
    logic             used;
    logic             tomb;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lphm_rd_t;

endpackage
`default_nettype wire

### hw/rtl/lphm_store.sv
// Slot store: per-slot live and tombstone flags plus the key/value memory.
`default_nettype none
module lphm_store (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [lphm_pkg::IDX_W-1:0]    rd_addr,
  input  wire lphm_pkg::lphm_wr_t      wr,
  input  wire [lphm_pkg::KEY_W-1:0]    wr_key,
  input  wire [lphm_pkg::VAL_W-1:0]    wr_value,
  output lphm_pkg::lphm_rd_t           rd
);
  import lphm_pkg::*;

  logic [TABLE_SLOTS-1:0]   used_r;
  logic [TABLE_SLOTS-1:0]   tomb_r;
  logic [KEY_W+VAL_W-1:0]   mem [TABLE_SLOTS];
  logic [KEY_W+VAL_W-1:0]   mem_q_r;
  logic                     used_q_r;
  logic                     tomb_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      tomb_r <= '0;
    end else begin
      if (wr.mark_live) begin
        used_r[wr.addr] <= 1'b1;
        tomb_r[wr.addr] <= 1'b0;
      end else if (wr.mark_tomb) begin
        used_r[wr.addr] <= 1'b0;
        tomb_r[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.mem_we) begin
      mem[wr.addr] <= {wr_key, wr_value};
    end
    mem_q_r  <= mem[rd_addr];
    used_q_r <= used_r[rd_addr];
    tomb_q_r <= tomb_r[rd_addr];
  end

  assign rd.used  = used_q_r;
  assign rd.tomb  = tomb_q_r;
  assign rd.key   = mem_q_r[KEY_W+VAL_W-1:VAL_W];
  assign rd.value = mem_q_r[VAL_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/lphm_ctrl.sv
// Probe sequencer with the shared key compare, live count and result register.
`default_nettype none
module lphm_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [lphm_pkg::CMD_W-1:0]    in_cmd,
  input  wire [lphm_pkg::KEY_W-1:0]    in_key,
  input  wire [lphm_pkg::VAL_W-1:0]    in_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [lphm_pkg::STAT_W-1:0]  out_status,
  output logic [lphm_pkg::VAL_W-1:0]   out_value,
  output logic [lphm_pkg::IDX_W-1:0]   rd_addr,
  input  wire lphm_pkg::lphm_rd_t      rd,
  output lphm_pkg::lphm_wr_t           wr,
  output logic [lphm_pkg::KEY_W-1:0]   wr_key,
  output logic [lphm_pkg::VAL_W-1:0]   wr_value
);
  import lphm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]        state_r,      state_nxt;
  logic [CMD_W-1:0]  cmd_r,        cmd_nxt;
  logic [KEY_W-1:0]  key_r,        key_nxt;
  logic [VAL_W-1:0]  value_r,      value_nxt;
  logic [IDX_W-1:0]  idx_r,        idx_nxt;
  logic [CNT_W-1:0]  cnt_r,        cnt_nxt;
  logic              have_tomb_r,  have_tomb_nxt;
  logic [IDX_W-1:0]  tomb_idx_r,   tomb_idx_nxt;
  logic [CNT_W-1:0]  live_r,       live_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [VAL_W-1:0]  res_value_r,  res_value_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_value_r,  out_value_nxt;

  logic hit;
  logic free_slot;
  logic tomb_slot;
  logic last_slot;
  logic any_tomb;
  logic out_free;

  assign hit       = rd.used && (rd.key == key_r);
  assign tomb_slot = !rd.used && rd.tomb;
  assign free_slot = !rd.used && !rd.tomb;
  assign last_slot = (cnt_r == CNT_W'(TABLE_SLOTS - 1));
  assign any_tomb  = have_tomb_r || tomb_slot;
  assign out_free  = !out_valid_r || out_ready;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign rd_addr    = idx_r;
  assign wr_key     = key_r;
  assign wr_value   = value_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    have_tomb_nxt  = have_tomb_r;
    tomb_idx_nxt   = tomb_idx_r;
    live_nxt       = live_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    wr             = '0;
    wr.addr        = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt       = in_cmd;
          key_nxt       = in_key;
          value_nxt     = in_value;
          idx_nxt       = in_key[IDX_W-1:0];
          cnt_nxt       = '0;
          have_tomb_nxt = 1'b0;
          res_value_nxt = '0;
          if (in_cmd == CMD_SET || in_cmd == CMD_GET || in_cmd == CMD_DEL) begin
            state_nxt = S_READ;
          end else begin
            res_status_nxt = ST_MISSING;
            state_nxt      = S_RESP;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_r == CMD_SET) begin
          if (hit) begin
            wr.mem_we      = 1'b1;
            res_status_nxt = ST_OK;
            state_nxt      = S_RESP;
          end else if (free_slot || last_slot) begin
            state_nxt = S_RESP;
            if (live_r >= CNT_W'(LOAD_LIMIT)) begin
              res_status_nxt = ST_FULL;
            end else if (any_tomb || free_slot) begin
              wr.mem_we      = 1'b1;
              wr.mark_live   = 1'b1;
              wr.addr        = have_tomb_r ? tomb_idx_r : idx_r;
              live_nxt       = live_r + 1'b1;
              res_status_nxt = ST_OK;
            end else begin
              res_status_nxt = ST_FULL;
            end
          end else begin
            if (tomb_slot && !have_tomb_r) begin
              have_tomb_nxt = 1'b1;
              tomb_idx_nxt  = idx_r;
            end
            idx_nxt   = idx_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_READ;
          end
        end else begin
          if (hit) begin
            res_status_nxt = ST_OK;
            state_nxt      = S_RESP;
            if (cmd_r == CMD_GET) begin
              res_value_nxt = rd.value;
            end else begin
              wr.mark_tomb = 1'b1;
              if (live_r != '0) begin
                live_nxt = live_r - 1'b1;
              end
            end
          end else if (free_slot || last_slot) begin
            res_status_nxt = ST_MISSING;
            state_nxt      = S_RESP;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    have_tomb_r  <= have_tomb_nxt;
    tomb_idx_r   <= tomb_idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/linear_probe_hash_map_top.sv
// Top level of the linear probing hash map (set, get, delete on 64-bit keys).
// Up to 256 slots are probed per item; cmd 3 skips the probe and answers missing.
// One item is in work at a time, so a new item is taken only once the last result
// is registered; each probe step is a registered slot read plus a compare.
// Reset (rst_n low, synchronous) clears all live and tombstone flags at once and
// the live count; the key/value memory needs no clearing pass.
`default_nettype none
module linear_probe_hash_map_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0 up: cmd[1:0], key[65:2], value[129:66], zero pad to 136 bits.
  input  wire [lphm_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // Fields from bit 0 up: status[1:0], value_out[65:2], zero pad to 72 bits.
  output logic [lphm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lphm_pkg::*;

  // Unpacked input fields.
  logic [CMD_W-1:0]  in_cmd;
  logic [KEY_W-1:0]  in_key;
  logic [VAL_W-1:0]  in_value;

  // Result fields from the sequencer's output register.
  logic [STAT_W-1:0] out_status;
  logic [VAL_W-1:0]  out_value;

  // Sequencer to store connections.
  logic [IDX_W-1:0]  rd_addr;
  lphm_rd_t          rd;
  lphm_wr_t          wr;
  logic [KEY_W-1:0]  wr_key;
  logic [VAL_W-1:0]  wr_value;

  assign in_cmd   = in_tdata[CMD_W-1:0];
  assign in_key   = in_tdata[CMD_W+KEY_W-1:CMD_W];
  assign in_value = in_tdata[IN_FIELDS_W-1:CMD_W+KEY_W];

  // The result is packed with zero padding above the last field.
  assign out_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_value, out_status};

  // The sequencer walks the probe run one slot at a time: it presents a slot
  // index, waits for the registered slot contents, then compares the key and
  // decides whether to stop, write, or step to the next slot.
  lphm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .in_value   (in_value),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_value  (out_value),
    .rd_addr    (rd_addr),
    .rd         (rd),
    .wr         (wr),
    .wr_key     (wr_key),
    .wr_value   (wr_value)
  );

  // The store keeps the slot flags in flip-flops so reset empties the table
  // at once, and the keys and values in a memory with one write and one registered read port.
  lphm_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rd       (rd)
  );

endmodule
`default_nettype wire

### hw/rtl/lphm_checker.sv
// Port-level assertion checker for the hash map and its bind statement.
`default_nettype none
`include "linear_probe_hash_map_top_assert.svh"
module lphm_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  input  wire                              in_tready,
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  input  wire [lphm_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import lphm_pkg::*;

  // A stalled result keeps its contents.
  `LPHM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Only one item is in work: the input closes right after a transfer.
  `LPHM_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // The reserved status code is never produced.
  `LPHM_ASSERT_SAME(a_status_code, clk, rst_n, out_tvalid, out_tdata[STAT_W-1:0] != ST_UNUSED)

  // Only a successful lookup carries a value.
  `LPHM_ASSERT_SAME(a_value_zero, clk, rst_n, out_tvalid && out_tdata[STAT_W-1:0] != ST_OK, out_tdata[OUT_FIELDS_W-1:STAT_W] == '0)

endmodule

bind linear_probe_hash_map_top lphm_checker u_lphm_checker (.*);
`default_nettype wire
